// ===== src/tfst_pkg.sv =====
// ----------------------------------------------------------------------------
// tfst_pkg: shared types and constants for the TCP flow state tracker
// Flow state codes, the registered packet summary and the flow record.
// ----------------------------------------------------------------------------
`default_nettype none

package tfst_pkg;

	localparam int unsigned STATE_W   = 4;
	localparam int unsigned PAYLOAD_W = 16;

	// flow state codes
	localparam logic [STATE_W-1:0] ST_NEW         = 4'd0;
	localparam logic [STATE_W-1:0] ST_SYN_SENT    = 4'd1;
	localparam logic [STATE_W-1:0] ST_SYN_RCVD    = 4'd2;
	localparam logic [STATE_W-1:0] ST_ESTABLISHED = 4'd3;
	localparam logic [STATE_W-1:0] ST_FIN_WAIT    = 4'd4;
	localparam logic [STATE_W-1:0] ST_CLOSE_WAIT  = 4'd5;
	localparam logic [STATE_W-1:0] ST_CLOSING     = 4'd6;
	localparam logic [STATE_W-1:0] ST_LAST_ACK    = 4'd7;
	localparam logic [STATE_W-1:0] ST_CLOSED      = 4'd8;
	localparam logic [STATE_W-1:0] ST_RESET       = 4'd9;

	// packet header summary; payload reduced to a nonzero bit
	typedef struct packed {
		logic rst;
		logic syn;
		logic fin;
		logic ack;
		logic rev;
		logic data;
	} pkt_t;

	// tracked flow record: state plus seen-marks
	typedef struct packed {
		logic [STATE_W-1:0] state;
		logic               syn_fwd;
		logic               syn_rev;
		logic               fin_fwd;
		logic               fin_rev;
		logic               rst;
	} flow_t;

	localparam flow_t FLOW_CLEAR = '{state: ST_NEW, default: 1'b0};

endpackage

`default_nettype wire

// ===== src/tfst_intf.sv =====
// ----------------------------------------------------------------------------
// tfst_intf: valid/ready channels of the TCP flow state tracker
// Packet header channel and flow result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfst_pkt_if;
	logic                             valid;
	logic                             ready;
	logic                             rst_flag;
	logic                             syn_flag;
	logic                             fin_flag;
	logic                             ack_flag;
	logic                             direction_reverse;
	logic [tfst_pkg::PAYLOAD_W-1:0]   payload_length;

	modport source (
		output valid, rst_flag, syn_flag, fin_flag, ack_flag,
		       direction_reverse, payload_length,
		input  ready
	);
	modport sink (
		input  valid, rst_flag, syn_flag, fin_flag, ack_flag,
		       direction_reverse, payload_length,
		output ready
	);
endinterface

interface tfst_res_if;
	logic                           valid;
	logic                           ready;
	logic [tfst_pkg::STATE_W-1:0]   flow_state;
	logic                           syn_fwd_seen;
	logic                           syn_rev_seen;
	logic                           fin_fwd_seen;
	logic                           fin_rev_seen;
	logic                           rst_seen;

	modport source (
		output valid, flow_state, syn_fwd_seen, syn_rev_seen, fin_fwd_seen,
		       fin_rev_seen, rst_seen,
		input  ready
	);
	modport sink (
		input  valid, flow_state, syn_fwd_seen, syn_rev_seen, fin_fwd_seen,
		       fin_rev_seen, rst_seen,
		output ready
	);
endinterface

`default_nettype wire

// ===== src/tcp_flow_state_tracker.sv =====
// ----------------------------------------------------------------------------
// tcp_flow_state_tracker: passive TCP connection state tracker for one flow
// Follows handshake, data and teardown from observed packet headers and
// reports the flow state and seen-marks after every packet.
// ----------------------------------------------------------------------------
//
//   channel  dir  beat contents
//   -------  ---  --------------------------------------------------------
//   pkt      in   rst/syn/fin/ack flags, direction_reverse, payload_length
//   flow     out  flow_state, syn/fin fwd/rev seen marks, rst_seen
//
// One packet per cycle sustained while flow takes its results. A packet is
// captured in the input stage, the next-state logic runs against the flow
// record in the following cycle, and the updated record lands in the result
// register when the input stage advances. The record and both stage valids
// clear on arst_n (state new, no marks). When flow is stalled the result
// register holds, the input stage holds one more packet, and pkt.ready drops
// until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_flow_state_tracker (
	input  wire             clk,
	input  wire             arst_n,
	tfst_pkt_if.sink        pkt,
	tfst_res_if.source      flow
);

	// input stage
	logic            pkt_valid_s1;
	tfst_pkg::pkt_t  pkt_s1;
	// result stage
	logic            res_valid_s2;
	tfst_pkg::flow_t res_s2;

	tfst_pkg::flow_t flow_cur;
	tfst_pkg::flow_t flow_nxt;
	logic            advance;

	// s1 moves into s2 when s2 is empty or its beat is taken now
	assign advance   = pkt_valid_s1 && (!res_valid_s2 || flow.ready);
	assign pkt.ready = !pkt_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			pkt_valid_s1 <= pkt.valid;
		end
	end

	// payload only matters as zero or nonzero
	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			pkt_s1.rst  <= pkt.rst_flag;
			pkt_s1.syn  <= pkt.syn_flag;
			pkt_s1.fin  <= pkt.fin_flag;
			pkt_s1.ack  <= pkt.ack_flag;
			pkt_s1.rev  <= pkt.direction_reverse;
			pkt_s1.data <= |pkt.payload_length;
		end
	end

	tfst_next u_next (
		.cur (flow_cur),
		.pkt (pkt_s1),
		.nxt (flow_nxt)
	);

	// flow record commits exactly once per packet, on advance
	tfst_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.nxt    (flow_nxt),
		.cur    (flow_cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (flow.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= flow_nxt;
		end
	end

	assign flow.valid        = res_valid_s2;
	assign flow.flow_state   = res_s2.state;
	assign flow.syn_fwd_seen = res_s2.syn_fwd;
	assign flow.syn_rev_seen = res_s2.syn_rev;
	assign flow.fin_fwd_seen = res_s2.fin_fwd;
	assign flow.fin_rev_seen = res_s2.fin_rev;
	assign flow.rst_seen     = res_s2.rst;

endmodule

`default_nettype wire

// ===== src/tfst_next.sv =====
// ----------------------------------------------------------------------------
// tfst_next: flow next-state logic
// Combinational update of the flow record for one packet.
// ----------------------------------------------------------------------------
`default_nettype none

module tfst_next (
	input  tfst_pkg::flow_t cur,
	input  tfst_pkg::pkt_t  pkt,
	output tfst_pkg::flow_t nxt
);

	tfst_pkg::flow_t base;
	logic            term;
	logic            closing_st;
	logic            fin_both;

	always_comb begin
		term = (cur.state == tfst_pkg::ST_CLOSED) || (cur.state == tfst_pkg::ST_RESET);
		// restart on SYN clears all marks
		base = term ? tfst_pkg::FLOW_CLEAR : cur;
		closing_st = (base.state == tfst_pkg::ST_FIN_WAIT)
			|| (base.state == tfst_pkg::ST_CLOSE_WAIT)
			|| (base.state == tfst_pkg::ST_CLOSING)
			|| (base.state == tfst_pkg::ST_LAST_ACK);
		fin_both = 1'b0;
		nxt = base;

		if (pkt.rst) begin
			nxt = cur;
			nxt.rst = 1'b1;
			nxt.state = tfst_pkg::ST_RESET;
		end else if (term && !pkt.syn) begin
			nxt = cur;
		end else if (pkt.fin) begin
			if (pkt.rev) begin
				nxt.fin_rev = 1'b1;
			end else begin
				nxt.fin_fwd = 1'b1;
			end
			fin_both = nxt.fin_fwd && nxt.fin_rev;
			if (fin_both) begin
				nxt.state = tfst_pkg::ST_CLOSED;
			end else begin
				nxt.state = pkt.rev ? tfst_pkg::ST_CLOSE_WAIT : tfst_pkg::ST_FIN_WAIT;
			end
		end else if (closing_st) begin
			if (base.fin_fwd && base.fin_rev) begin
				nxt.state = tfst_pkg::ST_CLOSED;
			end else if (pkt.ack) begin
				if ((base.state == tfst_pkg::ST_FIN_WAIT) && pkt.rev) begin
					nxt.state = tfst_pkg::ST_CLOSING;
				end else if ((base.state == tfst_pkg::ST_CLOSE_WAIT) && !pkt.rev) begin
					nxt.state = tfst_pkg::ST_CLOSING;
				end
			end
		end else if (pkt.syn) begin
			if (pkt.rev) begin
				nxt.syn_rev = 1'b1;
			end else begin
				nxt.syn_fwd = 1'b1;
			end
			if (pkt.ack) begin
				nxt.state = tfst_pkg::ST_SYN_RCVD;
			end else if (base.state == tfst_pkg::ST_NEW) begin
				nxt.state = tfst_pkg::ST_SYN_SENT;
			end
		end else if (pkt.ack || pkt.data) begin
			case (base.state)
				tfst_pkg::ST_NEW,
				tfst_pkg::ST_SYN_SENT,
				tfst_pkg::ST_SYN_RCVD: nxt.state = tfst_pkg::ST_ESTABLISHED;
				default:               nxt.state = base.state;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/tfst_state.sv =====
// ----------------------------------------------------------------------------
// tfst_state: flow record register
// Holds the tracked state and marks; loads the update when a packet commits.
// ----------------------------------------------------------------------------
`default_nettype none

module tfst_state (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             load,
	input  tfst_pkg::flow_t nxt,
	output tfst_pkg::flow_t cur
);

	tfst_pkg::flow_t flow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_q <= tfst_pkg::FLOW_CLEAR;
		end else if (load) begin
			flow_q <= nxt;
		end
	end

	assign cur = flow_q;

endmodule

`default_nettype wire

// ===== tb/tb_tcp_flow_state_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_tcp_flow_state_tracker: self-checking bench for the TCP flow state tracker
// Drives packet header beats, keeps its own model of the flow record and
// compares every flow beat against it. The run covers directed handshake,
// teardown and reset cases, then random sessions mixed with random noise
// under changing idle patterns. It also holds off the result side for a
// long stretch, so the input side has to stall.
// ----------------------------------------------------------------------------

module tb_tcp_flow_state_tracker;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLDOFF_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n;

	tfst_pkt_if pkt_ch ();
	tfst_res_if flow_ch ();

	tcp_flow_state_tracker DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_ch),
		.flow   (flow_ch)
	);

	// model of the tracked flow, advanced on every accepted pkt beat
	tfst_pkg::flow_t tracked_flow = tfst_pkg::FLOW_CLEAR;
	// flow records still owed by the block, oldest first
	tfst_pkg::flow_t pending_flows[$];

	int pkt_beats      = 0;
	int flow_beats     = 0;
	int fail_count     = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	logic recv_hold    = 1'b0;
	event holdoff_go;

	// ------------------------------------------------------------------
	// clock, reset, watchdog
	// ------------------------------------------------------------------
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d flow records pending",
				cycle_count, pending_flows.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// next-state model of the flow record
	// ------------------------------------------------------------------
	function automatic tfst_pkg::flow_t advance_flow(tfst_pkg::flow_t f, tfst_pkg::pkt_t p);
		// RST always wins; other flags of the packet are dropped
		if (p.rst) begin
			f.rst = 1'b1;
			f.state = tfst_pkg::ST_RESET;
			return f;
		end
		// a terminated flow only comes back on a SYN, which wipes all marks
		if (f.state == tfst_pkg::ST_CLOSED || f.state == tfst_pkg::ST_RESET) begin
			if (!p.syn)
				return f;
			f = tfst_pkg::FLOW_CLEAR;
		end
		if (p.fin) begin
			if (p.rev)
				f.fin_rev = 1'b1;
			else
				f.fin_fwd = 1'b1;
			if (f.fin_fwd && f.fin_rev)
				f.state = tfst_pkg::ST_CLOSED;
			else
				f.state = p.rev ? tfst_pkg::ST_CLOSE_WAIT : tfst_pkg::ST_FIN_WAIT;
			return f;
		end
		// teardown states: only the ACK of the far side moves us on
		if (f.state == tfst_pkg::ST_FIN_WAIT || f.state == tfst_pkg::ST_CLOSE_WAIT ||
		    f.state == tfst_pkg::ST_CLOSING || f.state == tfst_pkg::ST_LAST_ACK) begin
			if (f.fin_fwd && f.fin_rev)
				f.state = tfst_pkg::ST_CLOSED;
			else if (p.ack && f.state == tfst_pkg::ST_FIN_WAIT && p.rev)
				f.state = tfst_pkg::ST_CLOSING;
			else if (p.ack && f.state == tfst_pkg::ST_CLOSE_WAIT && !p.rev)
				f.state = tfst_pkg::ST_CLOSING;
			return f;
		end
		if (p.syn) begin
			if (p.rev)
				f.syn_rev = 1'b1;
			else
				f.syn_fwd = 1'b1;
			if (p.ack)
				f.state = tfst_pkg::ST_SYN_RCVD;
			else if (f.state == tfst_pkg::ST_NEW)
				f.state = tfst_pkg::ST_SYN_SENT;
			return f;
		end
		// ACK or payload opens the flow, mid-stream pickup included
		if ((p.ack || p.data) && (f.state == tfst_pkg::ST_NEW ||
		    f.state == tfst_pkg::ST_SYN_SENT || f.state == tfst_pkg::ST_SYN_RCVD))
			f.state = tfst_pkg::ST_ESTABLISHED;
		return f;
	endfunction

	// ------------------------------------------------------------------
	// pkt side: one beat per call; valid stays up on return so that
	// back-to-back beats never toggle it within one time step
	// ------------------------------------------------------------------
	task automatic send_packet(input logic rst, input logic syn, input logic fin,
	                           input logic ack, input logic rev,
	                           input logic [tfst_pkg::PAYLOAD_W-1:0] len);
		tfst_pkg::pkt_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			pkt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pkt_ch.valid             <= 1'b1;
		pkt_ch.rst_flag          <= rst;
		pkt_ch.syn_flag          <= syn;
		pkt_ch.fin_flag          <= fin;
		pkt_ch.ack_flag          <= ack;
		pkt_ch.direction_reverse <= rev;
		pkt_ch.payload_length    <= len;
		do
			@(posedge clk);
		while (pkt_ch.ready !== 1'b1);
		p = '{rst: rst, syn: syn, fin: fin, ack: ack, rev: rev, data: (len != '0)};
		tracked_flow = advance_flow(tracked_flow, p);
		pending_flows.push_back(tracked_flow);
		pkt_beats++;
	endtask

	// random single bit
	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	// payload: zero, full scale or anything in between
	function automatic logic [tfst_pkg::PAYLOAD_W-1:0] pick_len(input bit nonzero);
		case ($urandom_range(3))
			0: return nonzero ? 16'd1 : 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(65535, nonzero ? 1 : 0));
		endcase
	endfunction

	task automatic send_noise_packet();
		send_packet(($urandom_range(7) == 0), rand_bit(), rand_bit(),
			rand_bit(), rand_bit(), pick_len(rand_bit()));
	endtask

	// full session: handshake, some data, teardown; sometimes aborted by RST
	task automatic send_tcp_session();
		bit closer;
		int n_data;
		send_packet(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0);
		if ($urandom_range(4) == 0)
			send_noise_packet();
		send_packet(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 16'd0);
		send_packet(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, pick_len(1'b0));
		n_data = $urandom_range(6);
		repeat (n_data)
			send_packet(1'b0, 1'b0, 1'b0, rand_bit(), rand_bit(), pick_len(1'b1));
		if ($urandom_range(9) == 0) begin
			send_packet(1'b1, rand_bit(), rand_bit(), rand_bit(),
				rand_bit(), pick_len(rand_bit()));
			return;
		end
		closer = rand_bit();
		send_packet(1'b0, 1'b0, 1'b1, 1'b1, closer, pick_len(rand_bit()));
		// data trailing the first FIN is ignored unless it carries the far side's ACK
		if ($urandom_range(2) == 0)
			send_packet(1'b0, rand_bit(), 1'b0, rand_bit(), rand_bit(), pick_len(1'b1));
		if ($urandom_range(3) != 0)
			send_packet(1'b0, 1'b0, 1'b0, 1'b1, ~closer, 16'd0);
		send_packet(1'b0, 1'b0, 1'b1, 1'b1, ~closer, 16'd0);
		send_packet(1'b0, 1'b0, 1'b0, 1'b1, closer, 16'd0);
	endtask

	task automatic drain_flows();
		pkt_ch.valid <= 1'b0;
		while (pending_flows.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// flow side: random ready, plus a long hold-off on request
	// ------------------------------------------------------------------
	always @(posedge clk)
		flow_ch.ready <= arst_n && !recv_hold && ($urandom_range(99) >= recv_idle_pct);

	initial begin
		forever begin
			@(holdoff_go);
			recv_hold <= 1'b1;
			repeat (HOLDOFF_CYCLES) @(posedge clk);
			recv_hold <= 1'b0;
		end
	end

	task automatic report_mismatch(input string what, input tfst_pkg::flow_t want,
	                               input tfst_pkg::flow_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%s at flow beat %0d: expected state %0d sf%b sr%b ff%b fr%b r%b,",
				what, flow_beats, want.state, want.syn_fwd, want.syn_rev,
				want.fin_fwd, want.fin_rev, want.rst,
				" got state %0d sf%b sr%b ff%b fr%b r%b",
				got.state, got.syn_fwd, got.syn_rev, got.fin_fwd, got.fin_rev, got.rst);
	endtask

	always @(posedge clk) begin
		tfst_pkg::flow_t got;
		tfst_pkg::flow_t want;
		if (arst_n && flow_ch.valid === 1'b1 && flow_ch.ready === 1'b1) begin
			got = '{state: flow_ch.flow_state, syn_fwd: flow_ch.syn_fwd_seen,
				syn_rev: flow_ch.syn_rev_seen, fin_fwd: flow_ch.fin_fwd_seen,
				fin_rev: flow_ch.fin_rev_seen, rst: flow_ch.rst_seen};
			if (pending_flows.size() == 0) begin
				report_mismatch("unexpected flow beat", tfst_pkg::FLOW_CLEAR, got);
			end else begin
				want = pending_flows.pop_front();
				if (got !== want)
					report_mismatch("flow mismatch", want, got);
			end
			flow_beats++;
		end
	end

	// ------------------------------------------------------------------
	// directed tests
	// ------------------------------------------------------------------

	// first packet after reset carries data only: picked up as established
	task automatic test_midstream_pickup();
		send_packet(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd100);
	endtask

	task automatic test_handshake();
		send_packet(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);     // RST
		send_packet(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0);     // SYN restarts
		send_packet(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0);     // SYN again, stays
		send_packet(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 16'd0);     // SYN-ACK
		send_packet(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0);     // ACK opens
		send_packet(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF);  // data
		send_packet(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0);     // SYN when open
		send_packet(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 16'd1);     // SYN-ACK when open
	endtask

	task automatic test_fin_teardown();
		send_packet(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0);     // FIN fwd
		send_packet(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 16'd512);   // ignored
		send_packet(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 16'd0);     // ACK rev -> closing
		send_packet(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 16'd0);     // FIN rev -> closed
		send_packet(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'hFFFF);  // no SYN, no change
		send_packet(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 16'd0);     // restart, FIN rev
		send_packet(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 16'd0);     // ACK same side
		send_packet(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0);     // ACK fwd -> closing
	endtask

	task automatic test_rst_and_restart();
		send_packet(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF);  // RST, rest ignored
		send_packet(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd7);     // no SYN, no change
		send_packet(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 16'd0);     // restart, syn_sent
		send_packet(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);     // RST
		send_packet(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0);     // restart, syn_rcvd
		send_packet(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'h8000);  // data opens
	endtask

	// ------------------------------------------------------------------
	// random tests
	// ------------------------------------------------------------------
	task automatic test_random_traffic(input int n_beats, input int s_pct, input int r_pct);
		int start;
		start = pkt_beats;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		while (pkt_beats - start < n_beats) begin
			if ($urandom_range(9) < 7)
				send_tcp_session();
			else
				repeat ($urandom_range(1, 6)) send_noise_packet();
		end
	endtask

	// result side frozen while beats keep coming: pkt.ready must drop
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		pkt_ch.valid <= 1'b0;
		-> holdoff_go;
		do
			@(posedge clk);
		while (recv_hold !== 1'b1);
		send_tcp_session();
		send_tcp_session();
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		pkt_ch.valid             <= 1'b0;
		pkt_ch.rst_flag          <= 1'b0;
		pkt_ch.syn_flag          <= 1'b0;
		pkt_ch.fin_flag          <= 1'b0;
		pkt_ch.ack_flag          <= 1'b0;
		pkt_ch.direction_reverse <= 1'b0;
		pkt_ch.payload_length    <= '0;
		send_idle_pct = 8;
		recv_idle_pct = 65;
		wait (arst_n === 1'b1);
		@(posedge clk);

		test_midstream_pickup();
		test_handshake();
		test_fin_teardown();
		test_rst_and_restart();
		test_random_traffic(550, 8, 65);
		test_random_traffic(550, 65, 8);
		test_backpressure();
		test_random_traffic(500, 0, 0);
		drain_flows();

		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/tfst_pkg.sv
src/tfst_intf.sv
src/tfst_next.sv
src/tfst_state.sv
src/tcp_flow_state_tracker.sv
tb/tb_tcp_flow_state_tracker.sv
